### rtl/core/mlk_pkg.sv
package mlk_pkg;

  // tick counter width; one unit saturates at 2^TICK_COUNT_WIDTH ticks
  localparam int TICK_COUNT_WIDTH = 20;
  localparam int UNIT_WIDTH = 20;
  localparam logic [UNIT_WIDTH-1:0] UNIT_LENGTH_RESET = UNIT_WIDTH'(100000);

  // width that holds both the unit register and the counter ceiling
  localparam int LIMIT_WIDTH =
      ((TICK_COUNT_WIDTH > UNIT_WIDTH) ? TICK_COUNT_WIDTH : UNIT_WIDTH) + 1;

  localparam logic [7:0] ASCII_SPACE   = 8'h20;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;

  localparam logic [2:0] DOT_UNITS      = 3'd1;
  localparam logic [2:0] DASH_UNITS     = 3'd3;
  localparam logic [2:0] SYMGAP_UNITS   = 3'd1;
  localparam logic [2:0] LETGAP_UNITS   = 3'd3;
  localparam logic [2:0] WORDGAP_UNITS  = 3'd7;

  // input kinds carried on s_tuser
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CHAR = 1'b1;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_MARK    = 5'b00010,
    PH_SYMGAP  = 5'b00100,
    PH_LETGAP  = 5'b01000,
    PH_WORDGAP = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [2:0] count;    // symbols in the letter
    logic [3:0] pattern;  // first symbol in bit 0, 1 = dash
  } letter_code_t;

  function automatic letter_code_t letter_code(input logic [4:0] idx);
    logic [6:0] code;
    case (idx)
      5'd0:  code = 7'h22;
      5'd1:  code = 7'h41;
      5'd2:  code = 7'h45;
      5'd3:  code = 7'h31;
      5'd4:  code = 7'h10;
      5'd5:  code = 7'h44;
      5'd6:  code = 7'h33;
      5'd7:  code = 7'h40;
      5'd8:  code = 7'h20;
      5'd9:  code = 7'h4E;
      5'd10: code = 7'h35;
      5'd11: code = 7'h42;
      5'd12: code = 7'h23;
      5'd13: code = 7'h21;
      5'd14: code = 7'h37;
      5'd15: code = 7'h46;
      5'd16: code = 7'h4B;
      5'd17: code = 7'h32;
      5'd18: code = 7'h30;
      5'd19: code = 7'h11;
      5'd20: code = 7'h34;
      5'd21: code = 7'h48;
      5'd22: code = 7'h36;
      5'd23: code = 7'h49;
      5'd24: code = 7'h4D;
      5'd25: code = 7'h43;
      default: code = 7'h00;
    endcase
    return letter_code_t'(code);
  endfunction

endpackage

### rtl/core/morse_letter_keyer_core.sv
// Morse letter keyer
//
// s_tdata carries an ASCII character, s_tuser says what the transfer is:
// 0 = one prescaler tick (character ignored), 1 = offer the character.
// Every input transfer gives exactly one output transfer on m_*, showing
// the keyer state after that item: lamps, busy, and whether an offered
// character was taken (only when idle) and whether it was ignored.
// Letters of either case key out in International Morse; a space keys a
// 7-unit silence; other characters are taken and dropped.
// cfg_data sets the unit length in ticks (0 acts as 1); write it only
// while idle. cfg_ready is always high.
// The state update and the result are computed in one pass from the
// accepted item and land in the state and output registers at the same
// edge. Throughput is one item per cycle while m_tready does not stall.
// s_tready follows the output register: it is high while the register is
// empty or being drained, so a stalled m_tready holds the result and
// stops the input after one pending item.
// Synchronous rst returns the keyer to idle, empties the output register
// and restores the unit length to 100000 ticks.
module morse_letter_keyer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // char_code[7:0]
  input  logic                          s_tuser,   // op
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // dot_lamp, dash_lamp, busy_res, accepted, ignored, zero fill [7:5]
  output logic [7:0]                    m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mlk_pkg::UNIT_WIDTH-1:0] cfg_data
);
  import mlk_pkg::*;

  localparam int TW = TICK_COUNT_WIDTH;

  // keyer state
  phase_t           phase, phase_next;
  logic [3:0]       symbol_pattern, symbol_pattern_next;
  logic [2:0]       symbols_left, symbols_left_next;
  logic [2:0]       units_left, units_left_next;
  logic [TW-1:0]    tick_count, tick_count_next;
  logic [UNIT_WIDTH-1:0] unit_length;

  logic             in_xfer;
  logic             acc, ign;
  logic [7:0]       ch_up;
  letter_code_t     code;
  logic [LIMIT_WIDTH-1:0] limit, tick_inc;
  logic [2:0]       units_dec, symbols_dec;
  logic [3:0]       pattern_shift;

  assign cfg_ready = 1'b1;
  assign s_tready  = ~m_tvalid | m_tready;
  assign in_xfer   = s_tvalid & s_tready;

  // fold lower case onto upper case, then look the letter up
  always_comb begin
    ch_up = s_tdata;
    if (s_tdata >= ASCII_LOWER_A && s_tdata <= ASCII_LOWER_Z) begin
      ch_up = s_tdata - CASE_OFFSET;
    end
  end

  assign code = letter_code(5'(ch_up - ASCII_UPPER_A));

  // effective unit: zero counts as one, saturate at the counter ceiling
  always_comb begin
    limit = LIMIT_WIDTH'(unit_length);
    if (unit_length == '0) begin
      limit = LIMIT_WIDTH'(1);
    end
    if (limit > (LIMIT_WIDTH'(1) << TW)) begin
      limit = LIMIT_WIDTH'(1) << TW;
    end
  end

  assign tick_inc      = LIMIT_WIDTH'(tick_count) + LIMIT_WIDTH'(1);
  assign units_dec     = (units_left != '0) ? units_left - 3'd1 : 3'd0;
  assign symbols_dec   = (symbols_left != '0) ? symbols_left - 3'd1 : 3'd0;
  assign pattern_shift = {1'b0, symbol_pattern[3:1]};

  always_comb begin
    phase_next          = phase;
    symbol_pattern_next = symbol_pattern;
    symbols_left_next   = symbols_left;
    units_left_next     = units_left;
    tick_count_next     = tick_count;
    acc                 = 1'b0;
    ign                 = 1'b0;

    if (s_tuser == OP_CHAR) begin
      if (phase == PH_IDLE) begin
        acc = 1'b1;
        if (ch_up >= ASCII_UPPER_A && ch_up <= ASCII_UPPER_Z) begin
          symbol_pattern_next = code.pattern;
          symbols_left_next   = code.count;
          phase_next          = PH_MARK;
          units_left_next     = code.pattern[0] ? DASH_UNITS : DOT_UNITS;
          tick_count_next     = '0;
        end else if (s_tdata == ASCII_SPACE) begin
          phase_next      = PH_WORDGAP;
          units_left_next = WORDGAP_UNITS;
          tick_count_next = '0;
        end else begin
          ign = 1'b1;
        end
      end
    end else if (phase != PH_IDLE) begin
      if (tick_inc >= limit) begin
        // one unit has gone by
        tick_count_next = '0;
        units_left_next = units_dec;
        if (units_dec == '0) begin
          case (phase)
            PH_MARK: begin
              phase_next      = PH_SYMGAP;
              units_left_next = SYMGAP_UNITS;
            end
            PH_SYMGAP: begin
              symbol_pattern_next = pattern_shift;
              symbols_left_next   = symbols_dec;
              if (symbols_dec != '0) begin
                phase_next      = PH_MARK;
                units_left_next = pattern_shift[0] ? DASH_UNITS : DOT_UNITS;
              end else begin
                phase_next      = PH_LETGAP;
                units_left_next = LETGAP_UNITS;
              end
            end
            default: begin
              phase_next          = PH_IDLE;
              symbol_pattern_next = '0;
              symbols_left_next   = '0;
            end
          endcase
        end
      end else begin
        tick_count_next = TW'(tick_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      symbol_pattern <= '0;
      symbols_left   <= '0;
      units_left     <= '0;
      tick_count     <= '0;
      unit_length    <= UNIT_LENGTH_RESET;
    end else begin
      if (in_xfer) begin
        phase          <= phase_next;
        symbol_pattern <= symbol_pattern_next;
        symbols_left   <= symbols_left_next;
        units_left     <= units_left_next;
        tick_count     <= tick_count_next;
      end
      if (cfg_valid && cfg_ready) begin
        unit_length <= cfg_data;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      m_tdata <= {3'b000, ign, acc, (phase_next != PH_IDLE),
                  (phase_next == PH_MARK) & symbol_pattern_next[0],
                  (phase_next == PH_MARK) & ~symbol_pattern_next[0]};
    end
  end

  // both lamps never lit together
  a_lamps_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("dot and dash lamps lit together");

  // a lit lamp means the keyer reports busy
  a_lamp_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[0] || m_tdata[1])) |-> m_tdata[2])
    else $error("lamp lit while not busy");

  // ignored only for a character that was taken, leaving the keyer idle
  a_ignored_taken: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[4]) |-> (m_tdata[3] && !m_tdata[2]))
    else $error("ignored flag without acceptance");

  // an active phase always has units to run
  a_units_active: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (units_left != '0))
    else $error("active phase with no units left");

  // a taken offer starts from idle
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && s_tuser == OP_CHAR && phase != PH_IDLE) |=> !m_tdata[3])
    else $error("offer taken while busy");

endmodule

### sim/morse_keyer_checker.sv
module morse_keyer_checker
  import mlk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [7:0]            s_tdata,
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [7:0]            m_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [UNIT_WIDTH-1:0] cfg_data,
  input  logic                  end_of_test,
  output int                    fail_count
);

  // one result transfer, lowest bit last
  typedef struct packed {
    logic ignored;
    logic accepted;
    logic busy;
    logic dash_lamp;
    logic dot_lamp;
  } lamp_state_t;

  // dots and dashes per letter, first symbol first
  string morse_of [26] = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
                           ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-",
                           ".-.", "...", "-", "..-", "...-", ".--", "-..-", "-.--",
                           "--.."};

  phase_t                kphase;
  logic [3:0]            pattern;
  logic [2:0]            syms_left;
  logic [2:0]            units_left;
  longint unsigned       ticks;
  logic [UNIT_WIDTH-1:0] unit_len;
  lamp_state_t           lamp_queue [$];
  bit                    end_seen;

  initial fail_count = 0;

  function automatic void start_mark();
    kphase     = PH_MARK;
    units_left = pattern[0] ? DASH_UNITS : DOT_UNITS;
    ticks      = 0;
  endfunction

  // advance the keyer by one accepted item and return the lamp state after it
  function automatic lamp_state_t key_item(input logic op, input logic [7:0] ch);
    lamp_state_t     res;
    logic [7:0]      c;
    longint unsigned limit;
    string           code;
    res = '0;
    c   = ch;
    if (op == OP_CHAR) begin
      if (kphase == PH_IDLE) begin
        res.accepted = 1'b1;
        if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) c = c - CASE_OFFSET;
        if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
          code    = morse_of[int'(c - ASCII_UPPER_A)];
          pattern = '0;
          for (int i = 0; i < code.len(); i++) pattern[i] = (code[i] == "-");
          syms_left = 3'(code.len());
          start_mark();
        end else if (c == ASCII_SPACE) begin
          kphase     = PH_WORDGAP;
          units_left = WORDGAP_UNITS;
          ticks      = 0;
        end else begin
          res.ignored = 1'b1;
        end
      end
    end else if (kphase != PH_IDLE) begin
      limit = (unit_len == 0) ? 1 : unit_len;
      if (limit > (64'd1 << TICK_COUNT_WIDTH)) limit = 64'd1 << TICK_COUNT_WIDTH;
      ticks++;
      if (ticks >= limit) begin
        ticks = 0;
        if (units_left != 0) units_left--;
        if (units_left == 0) begin
          case (kphase)
            PH_MARK: begin
              kphase     = PH_SYMGAP;
              units_left = SYMGAP_UNITS;
            end
            PH_SYMGAP: begin
              pattern = pattern >> 1;
              if (syms_left != 0) syms_left--;
              if (syms_left != 0) begin
                start_mark();
              end else begin
                kphase     = PH_LETGAP;
                units_left = LETGAP_UNITS;
              end
            end
            default: begin
              kphase    = PH_IDLE;
              pattern   = '0;
              syms_left = '0;
            end
          endcase
        end
      end
    end
    res.dot_lamp  = (kphase == PH_MARK) && !pattern[0];
    res.dash_lamp = (kphase == PH_MARK) && pattern[0];
    res.busy      = (kphase != PH_IDLE);
    return res;
  endfunction

  always @(posedge clk) begin
    lamp_state_t want;
    lamp_state_t got;
    if (rst) begin
      kphase     = PH_IDLE;
      pattern    = '0;
      syms_left  = '0;
      units_left = '0;
      ticks      = 0;
      unit_len   = UNIT_LENGTH_RESET;
      end_seen   = 1'b0;
      lamp_queue.delete();
    end else begin
      // results leave before the new item enters the queue
      if (m_tvalid && m_tready) begin
        got = lamp_state_t'(m_tdata[4:0]);
        if (lamp_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result transfer with nothing expected, data %h", $time, m_tdata);
        end else begin
          want = lamp_queue.pop_front();
          if (got.dot_lamp !== want.dot_lamp || got.dash_lamp !== want.dash_lamp ||
              got.busy !== want.busy || got.accepted !== want.accepted ||
              got.ignored !== want.ignored || m_tdata[7:5] !== 3'b000) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch exp dot=%b dash=%b busy=%b acc=%b ign=%b, got dot=%b dash=%b busy=%b acc=%b ign=%b fill=%b",
                       $time, want.dot_lamp, want.dash_lamp, want.busy, want.accepted,
                       want.ignored, got.dot_lamp, got.dash_lamp, got.busy, got.accepted,
                       got.ignored, m_tdata[7:5]);
          end
        end
      end
      if (cfg_valid && cfg_ready) unit_len = cfg_data;
      if (s_tvalid && s_tready) lamp_queue.push_back(key_item(s_tuser, s_tdata));
      if (end_of_test && !end_seen) begin
        end_seen = 1'b1;
        if (lamp_queue.size() != 0) begin
          fail_count += lamp_queue.size();
          $display("%0t: %0d results never arrived", $time, lamp_queue.size());
        end
      end
    end
  end

endmodule

### sim/morse_letter_keyer_core_tb.sv
module morse_letter_keyer_core_tb;
  import mlk_pkg::*;

  localparam int BUSY_BIT = 2;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;   // char_code
  logic                  s_tuser = 1'b0; // op
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;        // dot, dash, busy, accepted, ignored, fill
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [UNIT_WIDTH-1:0] cfg_data = '0;
  logic                  end_of_test = 1'b0;
  int                    fail_count;

  int sent_count   = 0;
  int results_seen = 0;
  bit last_busy    = 1'b0;
  bit calm         = 1'b0;  // no idling on either side while set

  morse_letter_keyer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  morse_keyer_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .end_of_test (end_of_test),
    .fail_count  (fail_count)
  );

  always #10 clk = ~clk;

  // receiver stalls about a third of the time
  always @(posedge clk) m_tready <= calm || ($urandom_range(99) >= 33);

  // track returned results and the last busy flag seen
  always @(posedge clk) begin
    if (rst) begin
      results_seen <= 0;
      last_busy    <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      last_busy    <= m_tdata[BUSY_BIT];
    end
  end

  task automatic send_item(input logic op, input logic [7:0] ch);
    while (!calm && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= ch;
    do @(posedge clk); while (!s_tready);
    sent_count++;
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_seen != sent_count);
  endtask

  // tick one at a time until the keyer reports idle
  task automatic settle_idle();
    wait_all_results();
    while (last_busy) begin
      send_item(OP_TICK, 8'($urandom_range(255)));
      wait_all_results();
    end
  endtask

  task automatic write_unit(input logic [UNIT_WIDTH-1:0] len);
    settle_idle();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // with keying set, mostly letters or spaces each followed by span/3 to span+4 ticks,
  // with stray offers and ticks mixed in; span is at least the ticks for the longest letter
  task automatic run_random(input int n, input int span, input bit keying);
    int         first;
    int         roll;
    logic [7:0] ch;
    first = sent_count;
    while (sent_count - first < n) begin
      roll = $urandom_range(99);
      if (keying && roll < 75) begin
        if ($urandom_range(99) < 15) begin
          ch = ASCII_SPACE;
        end else begin
          ch = ASCII_UPPER_A + 8'($urandom_range(25));
          if ($urandom_range(1)) ch = ch + CASE_OFFSET;
        end
        send_item(OP_CHAR, ch);
        repeat ($urandom_range(span + 4, span / 3)) begin
          if ($urandom_range(99) < 8) send_item(OP_CHAR, 8'($urandom_range(255)));
          else send_item(OP_TICK, 8'($urandom_range(255)));
        end
      end else if (roll % 2) begin
        ch = 8'($urandom_range(255));
        // with a huge unit nothing that starts keying may be offered
        while (!keying && ((ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_Z) ||
                           (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z) ||
                           ch == ASCII_SPACE))
          ch = 8'($urandom_range(255));
        send_item(OP_CHAR, ch);
      end else begin
        send_item(OP_TICK, 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset unit length: only idle-safe items, ignored characters and idle ticks
    send_item(OP_CHAR, 8'h00);
    send_item(OP_CHAR, 8'hFF);
    send_item(OP_CHAR, ASCII_UPPER_A - 8'd1);
    send_item(OP_TICK, 8'hA5);

    // one tick per unit: a letter, an offer while busy, a word gap, edges of the ranges
    write_unit(20'd1);
    send_item(OP_CHAR, ASCII_UPPER_A);
    send_item(OP_CHAR, ASCII_UPPER_A + 8'd4);
    repeat (9) send_item(OP_TICK, 8'h00);
    settle_idle();
    send_item(OP_CHAR, ASCII_SPACE);
    settle_idle();
    send_item(OP_CHAR, ASCII_UPPER_Z + 8'd1);
    send_item(OP_CHAR, ASCII_LOWER_A - 8'd1);
    send_item(OP_CHAR, ASCII_LOWER_Z + 8'd1);

    run_random(110, 19, 1'b1);
    // sender holds off until everything is back, then a stretch without idling
    wait_all_results();
    calm = 1'b1;
    run_random(60, 19, 1'b1);
    calm = 1'b0;

    write_unit(20'd2);
    run_random(70, 38, 1'b1);
    write_unit(20'd0);
    run_random(50, 19, 1'b1);
    write_unit(20'd3);
    run_random(40, 57, 1'b1);
    write_unit(20'hFFFFF);
    run_random(20, 4, 1'b0);

    wait_all_results();
    repeat (5) @(posedge clk);
    end_of_test <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
rtl/core/mlk_pkg.sv
rtl/core/morse_letter_keyer_core.sv
sim/morse_keyer_checker.sv
sim/morse_letter_keyer_core_tb.sv
